// File: hw/rtl/lld_pkg.sv
// Package for the linked-list deque: command and status codes, transfer structs.
// No dependencies.
package lld_pkg;

   localparam logic [2:0] CMD_ADD_FRONT = 3'd0;
   localparam logic [2:0] CMD_ADD_REAR  = 3'd1;
   localparam logic [2:0] CMD_REMOVE    = 3'd2;
   localparam logic [2:0] CMD_POP_FRONT = 3'd3;
   localparam logic [2:0] CMD_POP_REAR  = 3'd4;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_EMPTY    = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;
   localparam logic [1:0] ST_NOTFOUND = 2'd3;

   typedef struct packed {
      logic        [2:0]  cmd;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic        [1:0]  status;
      logic        [6:0]  count;
      logic signed [31:0] front_value;
      logic signed [31:0] rear_value;
   } rsp_type;

endpackage

// File: hw/rtl/linked_list_deque.sv
// Linked-list deque: doubly linked list of values in node memories with a free chain.
// Depends on lld_pkg.
// State path, transfer to result strobe: add ALLOC, ENDRD, ENDOUT; pop ULINK, UREAD, UFIX,
//   ENDRD, ENDOUT; refused or undefined ENDRD, ENDOUT; remove by value SRD and SCMP per node
//   compared, then UFIX on a match; link and value memory reads are registered.
// One command at a time; busy drops in the response strobe cycle, so the next transfer
//   can land at the edge that ends it. Reset (synchronous) clears control; the free chain
//   uses a fill mark, so no clearing pass is needed. Responses cannot be stalled.
module linked_list_deque #(
   parameter int CAPACITY   = 64,
   parameter int VALUE_BITS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  lld_pkg::req_type req_data,
   output logic             rsp_valid,
   output lld_pkg::rsp_type rsp_data
);
   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   typedef logic [AW-1:0] idx_type;
   typedef logic [VALUE_BITS-1:0] val_type;

   typedef enum logic [3:0] {
      S_IDLE, S_ALLOC, S_SRD, S_SCMP, S_ULINK, S_UREAD, S_UFIX, S_ENDRD, S_ENDOUT
   } state_type;

   // node memories
   val_type vmem [CAPACITY];
   idx_type nmem [CAPACITY];
   idx_type pmem [CAPACITY];
   idx_type fmem [CAPACITY];

   state_type state_ff;
   logic [2:0] cmd_ff;
   val_type    val_ff;
   idx_type    head_ff, tail_ff, fhead_ff, cur_ff;
   logic [CW-1:0] cnt_ff, walk_ff, fill_ff;
   logic [1:0] st_ff;
   val_type    vrd_ff, vrd2_ff;
   idx_type    nrd_ff, prd_ff, frd_ff;
   logic       rv_ff;
   lld_pkg::rsp_type rsp_ff;

   // link the old end to the new node in the cycle after ALLOC
   logic    link_ff;
   idx_type link_node_ff, link_tgt_ff;
   logic    link_front_ff;

   // read/write request lines (one read address per memory per cycle)
   idx_type ra, fra;
   logic    vwe, nwe, pwe, fwe;
   idx_type vwa, nwa, pwa, fwa;
   val_type vwd;
   idx_type nwd, pwd, fwd;

   // a node at the fill mark has never been taken: its free link is the next index
   logic    fresh;
   idx_type fill_next;
   always_comb begin
      fresh = (fill_ff != CW'(CAPACITY)) && (CW'(fhead_ff) == fill_ff);
      if (!fresh) fill_next = frd_ff;
      else fill_next = (fhead_ff == idx_type'(CAPACITY - 1)) ? '0 : fhead_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      vrd_ff <= vmem[ra];
      nrd_ff <= nmem[ra];
      prd_ff <= pmem[ra];
      frd_ff <= fmem[fra];
      if (vwe) vmem[vwa] <= vwd;
      if (nwe) nmem[nwa] <= nwd;
      if (pwe) pmem[pwa] <= pwd;
      if (fwe) fmem[fwa] <= fwd;
   end

   logic [2:0] cmd_in;
   val_type    v_in;
   always_comb begin
      cmd_in = req_data.cmd;
      v_in   = val_type'(signed'({{32{req_data.value[31]}}, req_data.value}));
   end

   function automatic logic [31:0] outv(val_type v);
      logic signed [VALUE_BITS+31:0] e;
      e = {{32{v[VALUE_BITS-1]}}, v};
      return e[31:0];
   endfunction

   // combinational memory control, by state
   always_comb begin
      ra = cur_ff; fra = fhead_ff;
      vwe = 1'b0; nwe = 1'b0; pwe = 1'b0; fwe = 1'b0;
      vwa = fhead_ff; nwa = fhead_ff; pwa = fhead_ff; fwa = cur_ff;
      vwd = val_ff; nwd = '0; pwd = '0; fwd = fhead_ff;
      case (state_ff)
         S_ALLOC: begin
            // write new node and splice it in
            vwe = 1'b1; nwe = 1'b1; pwe = 1'b1;
            if (cnt_ff != '0 && cmd_ff == lld_pkg::CMD_ADD_FRONT) begin
               nwd = head_ff;
            end else if (cnt_ff != '0) begin
               pwd = tail_ff;
            end
            ra = head_ff;
         end
         S_UFIX: begin
            // repair neighbor links and return node to the free chain
            fwe = 1'b1; fwa = cur_ff; fwd = fhead_ff;
            if (cnt_ff == CW'(1)) begin
            end else if (cur_ff == head_ff) begin
               pwe = 1'b1; pwa = nrd_ff; pwd = '0;
            end else if (cur_ff == tail_ff) begin
               nwe = 1'b1; nwa = prd_ff; nwd = '0;
            end else begin
               nwe = 1'b1; nwa = prd_ff; nwd = nrd_ff;
               pwe = 1'b1; pwa = nrd_ff; pwd = prd_ff;
            end
         end
         S_ENDRD: begin
            ra = head_ff;
            // point the old end at the node added last cycle
            if (link_ff) begin
               if (link_front_ff) begin
                  pwe = 1'b1; pwa = link_tgt_ff; pwd = link_node_ff;
               end else begin
                  nwe = 1'b1; nwa = link_tgt_ff; nwd = link_node_ff;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      rv_ff   <= !reset && (state_ff == S_ENDOUT);
      link_ff <= !reset && (state_ff == S_ALLOC) && (cnt_ff != '0);
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff <= '0; tail_ff <= '0; fhead_ff <= '0;
         cnt_ff <= '0; fill_ff <= '0;
      end else begin
         case (state_ff)
            S_IDLE: if (start && !rv_ff) begin
               cmd_ff <= cmd_in; val_ff <= v_in;
               walk_ff <= '0;
               cur_ff <= (cmd_in == lld_pkg::CMD_POP_REAR) ? tail_ff : head_ff;
               case (cmd_in)
                  lld_pkg::CMD_ADD_FRONT, lld_pkg::CMD_ADD_REAR:
                     if (cnt_ff == CW'(CAPACITY)) begin
                        st_ff <= lld_pkg::ST_FULL; state_ff <= S_ENDRD;
                     end else begin
                        st_ff <= lld_pkg::ST_OK; state_ff <= S_ALLOC;
                     end
                  lld_pkg::CMD_REMOVE:
                     if (cnt_ff == '0) begin
                        st_ff <= lld_pkg::ST_EMPTY; state_ff <= S_ENDRD;
                     end else begin
                        st_ff <= lld_pkg::ST_OK; state_ff <= S_SRD;
                     end
                  lld_pkg::CMD_POP_FRONT, lld_pkg::CMD_POP_REAR:
                     if (cnt_ff == '0) begin
                        st_ff <= lld_pkg::ST_EMPTY; state_ff <= S_ENDRD;
                     end else begin
                        st_ff <= lld_pkg::ST_OK; state_ff <= S_ULINK;
                     end
                  default: begin
                     st_ff <= lld_pkg::ST_OK; state_ff <= S_ENDRD;
                  end
               endcase
            end
            S_ALLOC: begin
               // frd_ff holds free link of fhead (read issued last cycle)
               fhead_ff <= fill_next;
               if (fresh) fill_ff <= fill_ff + 1'b1;
               if (cnt_ff == '0) begin
                  head_ff <= fhead_ff; tail_ff <= fhead_ff;
               end else begin
                  link_node_ff <= fhead_ff;
                  if (cmd_ff == lld_pkg::CMD_ADD_FRONT) begin
                     link_front_ff <= 1'b1; link_tgt_ff <= head_ff; head_ff <= fhead_ff;
                  end else begin
                     link_front_ff <= 1'b0; link_tgt_ff <= tail_ff; tail_ff <= fhead_ff;
                  end
               end
               cnt_ff <= cnt_ff + 1'b1;
               state_ff <= S_ENDRD;
            end
            S_SRD: state_ff <= S_SCMP;          // read of cur in flight
            S_SCMP: begin
               if (vrd_ff == val_ff) begin
                  state_ff <= S_UFIX;             // links already read
               end else if (walk_ff + 1'b1 == cnt_ff) begin
                  st_ff <= lld_pkg::ST_NOTFOUND; state_ff <= S_ENDRD;
               end else begin
                  walk_ff <= walk_ff + 1'b1; cur_ff <= nrd_ff; state_ff <= S_SRD;
               end
            end
            S_ULINK: state_ff <= S_UREAD;
            S_UREAD: state_ff <= S_UFIX;
            S_UFIX: begin
               if (cnt_ff == CW'(1)) begin
                  head_ff <= '0; tail_ff <= '0;
               end else if (cur_ff == head_ff) head_ff <= nrd_ff;
               else if (cur_ff == tail_ff) tail_ff <= prd_ff;
               cnt_ff <= cnt_ff - 1'b1;
               fhead_ff <= cur_ff;
               state_ff <= S_ENDRD;
            end
            S_ENDRD: begin
               // head value read now; tail value next
               cur_ff <= tail_ff;
               state_ff <= S_ENDOUT;
            end
            S_ENDOUT: begin
               vrd2_ff <= vrd_ff;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // tail read issues in S_ENDOUT (ra = cur_ff = tail); head data captured there
   logic out_ff;
   always_ff @(posedge clock) begin
      if (reset) out_ff <= 1'b0;
      else out_ff <= rv_ff;
      if (rv_ff) begin
         rsp_ff.status      <= st_ff;
         rsp_ff.count       <= 7'(cnt_ff);
         rsp_ff.front_value <= (cnt_ff == '0) ? '0 : outv(vrd2_ff);
         rsp_ff.rear_value  <= (cnt_ff == '0) ? '0 : outv(vrd_ff);
      end
   end

   assign busy      = (state_ff != S_IDLE) || rv_ff;
   assign rsp_valid = out_ff;
   assign rsp_data  = rsp_ff;
endmodule

// File: hw/rtl/lld_checker.sv
// Port-level checker for the linked-list deque, bound to the top level.
// Depends on lld_pkg.
module lld_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input lld_pkg::rsp_type rsp_data
);
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("no busy after transfer");
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("double response");
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("busy during response");
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.count == 7'd0 |->
      rsp_data.front_value == 32'sd0 && rsp_data.rear_value == 32'sd0)
      else $error("empty list values nonzero");
endmodule

bind linked_list_deque lld_checker u_lld_checker (.*);
